### hw/rtl/pts_pkg.sv
// Shared types and constants for the priority thread scheduler.
package pts_pkg;

	localparam int THREAD_SLOTS = 8;
	localparam int EVENT_SLOTS  = 4;
	localparam int SLOT_W   = $clog2(THREAD_SLOTS);
	localparam int CNT_W    = $clog2(THREAD_SLOTS + 1);
	localparam int EVT_W    = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
	localparam int ECNT_W   = $clog2(EVENT_SLOTS + 1);
	localparam int PRIO_W   = 8;
	localparam int BEST_W   = PRIO_W + 1;
	localparam int ID_HIGH_W = 16;
	localparam int ID_LOW_W  = 16;
	localparam int TIME_W   = 32;

	typedef enum logic [2:0] {
		REQ_ADD_THREAD   = 3'd0,
		REQ_ADD_PERIODIC = 3'd1,
		REQ_LAUNCH       = 3'd2,
		REQ_TICK         = 3'd3,
		REQ_SLEEP        = 3'd4,
		REQ_KILL_ID      = 3'd5,
		REQ_KILL_SELF    = 3'd6,
		REQ_SET_BLOCKED  = 3'd7
	} req_t;

	typedef enum logic [2:0] {
		STS_OK          = 3'd0,
		STS_LIMIT       = 3'd1,
		STS_NO_THREADS  = 3'd2,
		STS_KILL_LAST   = 3'd3,
		STS_NOT_FOUND   = 3'd4,
		STS_NOT_RUNNING = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_EXEC, ST_WAKE, ST_RINIT, ST_RSTEP, ST_EMIT
	} state_t;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [7:0]  prio_in;
		logic [31:0] period_in;
		logic [31:0] sleep_ticks;
		logic [31:0] target_id;
		logic        block_flag;
	} req_in_t;

	typedef struct packed {
		logic        item_kind;
		logic [2:0]  status;
		logic [1:0]  fired_event;
		logic [31:0] new_id;
		logic [31:0] running_id;
		logic [2:0]  running_slot;
		logic [3:0]  live_threads;
		logic        last;
	} res_out_t;

	// write controls for one slot cell
	typedef struct packed {
		logic                 alive_we;
		logic                 alive_d;
		logic                 asleep_we;
		logic                 asleep_d;
		logic                 blocked_we;
		logic                 blocked_d;
		logic                 wake_we;
		logic [TIME_W-1:0]    wake_d;
		logic                 prio_we;
		logic [PRIO_W-1:0]    prio_d;
		logic                 idh_we;
		logic [ID_HIGH_W-1:0] idh_d;
		logic                 nxt_we;
		logic [SLOT_W-1:0]    nxt_d;
		logic                 prv_we;
		logic [SLOT_W-1:0]    prv_d;
		logic                 wake_chk;
	} slot_cmd_t;

	typedef struct packed {
		logic                 alive;
		logic                 asleep;
		logic                 blocked;
		logic [PRIO_W-1:0]    prio;
		logic [ID_HIGH_W-1:0] id_high;
		logic [SLOT_W-1:0]    nxt;
		logic [SLOT_W-1:0]    prv;
	} slot_stat_t;

	// search results passed from cell to cell
	typedef struct packed {
		logic              free_any;
		logic [SLOT_W-1:0] free_idx;
		logic              alive_any;
		logic [SLOT_W-1:0] alive_idx;
		logic              min_any;
		logic [PRIO_W-1:0] min_prio;
		logic [SLOT_W-1:0] min_idx;
		logic              match_any;
		logic [SLOT_W-1:0] match_idx;
	} slot_chain_t;

	typedef struct packed {
		logic              wr;
		logic [TIME_W-1:0] period_d;
		logic [TIME_W-1:0] due_d;
		logic              tick;
	} evt_cmd_t;

endpackage

### hw/rtl/pts_slot_cell.sv
// One thread slot: its state plus one link of the search chain.
module pts_slot_cell import pts_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [SLOT_W-1:0] index,
	input  slot_cmd_t         cmd,
	input  logic [TIME_W-1:0] time_now,
	input  logic [31:0]       target_id,
	input  slot_chain_t       chain_in,
	output slot_chain_t       chain_out,
	output slot_stat_t        stat
);

	logic                 alive_q, asleep_q, blocked_q;
	logic [TIME_W-1:0]    wake_q;
	logic [PRIO_W-1:0]    prio_q;
	logic [ID_HIGH_W-1:0] idh_q;
	logic [SLOT_W-1:0]    nxt_q, prv_q;
	logic                 wake_hit;

	assign wake_hit = cmd.wake_chk && alive_q && asleep_q && (wake_q == time_now);

	// marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q   <= 1'b0;
			asleep_q  <= 1'b0;
			blocked_q <= 1'b0;
		end else begin
			if (cmd.alive_we) alive_q <= cmd.alive_d;
			if (cmd.asleep_we) asleep_q <= cmd.asleep_d;
			else if (wake_hit) asleep_q <= 1'b0;
			if (cmd.blocked_we) blocked_q <= cmd.blocked_d;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.wake_we) wake_q <= cmd.wake_d;
		else if (wake_hit) wake_q <= '0;
		if (cmd.prio_we) prio_q <= cmd.prio_d;
		if (cmd.idh_we) idh_q <= cmd.idh_d;
		if (cmd.nxt_we) nxt_q <= cmd.nxt_d;
		if (cmd.prv_we) prv_q <= cmd.prv_d;
	end

	assign stat = '{alive: alive_q, asleep: asleep_q, blocked: blocked_q, prio: prio_q,
		id_high: idh_q, nxt: nxt_q, prv: prv_q};

	// lowest free, lowest live, lowest live of least priority, lowest id match
	always_comb begin
		chain_out = chain_in;
		if (!chain_in.free_any && !alive_q) begin
			chain_out.free_any = 1'b1;
			chain_out.free_idx = index;
		end
		if (!chain_in.alive_any && alive_q) begin
			chain_out.alive_any = 1'b1;
			chain_out.alive_idx = index;
		end
		if (alive_q && (!chain_in.min_any || prio_q < chain_in.min_prio)) begin
			chain_out.min_any  = 1'b1;
			chain_out.min_prio = prio_q;
			chain_out.min_idx  = index;
		end
		if (!chain_in.match_any && alive_q && ({idh_q, ID_LOW_W'(index)} == target_id)) begin
			chain_out.match_any = 1'b1;
			chain_out.match_idx = index;
		end
	end

endmodule

### hw/rtl/pts_event_cell.sv
// One periodic event: period and due time, fires when due equals the time.
module pts_event_cell import pts_pkg::*; (
	input  logic              clk,
	input  evt_cmd_t          cmd,
	input  logic [TIME_W-1:0] time_now,
	output logic              fire
);

	logic [TIME_W-1:0] period_q, due_q;

	assign fire = cmd.tick && (due_q == time_now);

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			period_q <= cmd.period_d;
			due_q    <= cmd.due_d;
		end else if (fire) begin
			due_q <= due_q + period_q;
		end
	end

endmodule

### hw/rtl/priority_thread_scheduler.sv
// Priority thread scheduler: sequencer over a row of slot cells and event cells.
// Sequence: add, periodic, launch and failed requests pass EXEC and then EMIT; requests
// that reschedule pass EXEC, RINIT and the ring walk in RSTEP, one slot per cycle, and a
// tick passes WAKE before RINIT; EMIT issues one item per fired event, then the outcome.
// One request at a time; busy is high until the outcome item is issued.
// Results cannot be stalled. Reset clears the slot marks, the thread, id and event counters and the time at once.
module priority_thread_scheduler import pts_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  req_in_t  req,
	output logic     result_strobe,
	output res_out_t result
);

	state_t               state_q, state_d, exec_tgt;
	req_in_t              req_q, req_d;
	logic [CNT_W-1:0]     total_q, total_d, cnt_q, cnt_d;
	logic [ID_HIGH_W-1:0] addc_q, addc_d;
	logic [SLOT_W-1:0]    cur_q, cur_d, t_q, t_d, first_q, first_d, cand_q, cand_d;
	logic                 launched_q, launched_d, found_q, found_d;
	logic [TIME_W-1:0]    time_q, time_d;
	logic [ECNT_W-1:0]    etot_q, etot_d;
	logic [EVENT_SLOTS-1:0] fired_q, fired_d;
	logic [BEST_W-1:0]    best_q, best_d;
	status_t              status_q, status_d;
	logic [31:0]          nid_q, nid_d;
	res_out_t             res_q, res_d;
	logic                 strobe_q, strobe_d;

	slot_cmd_t   cmd [THREAD_SLOTS];
	slot_stat_t  stat [THREAD_SLOTS];
	slot_chain_t chain [THREAD_SLOTS+1];
	evt_cmd_t    ecmd [EVENT_SLOTS];
	logic [EVENT_SLOTS-1:0] efire;

	assign chain[0] = '0;

	genvar g;
	generate
		for (g = 0; g < THREAD_SLOTS; g++) begin : g_slot
			pts_slot_cell u_cell (
				.clk(clk), .arst_n(arst_n), .index(SLOT_W'(g)), .cmd(cmd[g]),
				.time_now(time_q), .target_id(req_q.target_id),
				.chain_in(chain[g]), .chain_out(chain[g+1]), .stat(stat[g])
			);
		end
		for (g = 0; g < EVENT_SLOTS; g++) begin : g_evt
			pts_event_cell u_evt (
				.clk(clk), .cmd(ecmd[g]), .time_now(time_q), .fire(efire[g])
			);
		end
	endgenerate

	assign busy          = (state_q != ST_IDLE);
	assign result_strobe = strobe_q;
	assign result        = res_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (start) state_d = ST_EXEC;
			ST_EXEC:  state_d = exec_tgt;
			ST_WAKE:  state_d = ST_RINIT;
			ST_RINIT: state_d = ST_RSTEP;
			ST_RSTEP: if (cnt_q == total_q) state_d = ST_EMIT;
			ST_EMIT:  if (fired_q == '0) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// datapath and cell commands
	always_comb begin
		logic [SLOT_W-1:0] s, j, pj, p, n;
		logic [EVT_W-1:0]  ev;
		logic ready;
		s = '0; j = '0; pj = '0; p = '0; n = '0; ev = '0; ready = 1'b0;
		exec_tgt   = ST_EMIT;
		req_d      = req_q;
		total_d    = total_q;
		addc_d     = addc_q;
		cur_d      = cur_q;
		launched_d = launched_q;
		time_d     = time_q;
		etot_d     = etot_q;
		fired_d    = fired_q;
		t_d        = t_q;
		first_d    = first_q;
		cand_d     = cand_q;
		best_d     = best_q;
		found_d    = found_q;
		cnt_d      = cnt_q;
		status_d   = status_q;
		nid_d      = nid_q;
		res_d      = res_q;
		strobe_d   = 1'b0;
		for (int k = 0; k < THREAD_SLOTS; k++) cmd[k] = '0;
		for (int e = 0; e < EVENT_SLOTS; e++) ecmd[e] = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					req_d    = req;
					fired_d  = '0;
					status_d = STS_OK;
					nid_d    = '0;
				end
			end
			ST_EXEC: begin
				unique case (req_t'(req_q.req_type))
					REQ_ADD_THREAD: begin
						if (!chain[THREAD_SLOTS].free_any) begin
							status_d = STS_LIMIT;
						end else begin
							s  = chain[THREAD_SLOTS].free_idx;
							j  = chain[THREAD_SLOTS].alive_idx;
							pj = stat[j].prv;
							for (int k = 0; k < THREAD_SLOTS; k++) begin
								if (SLOT_W'(k) == s) begin
									cmd[k].alive_we   = 1'b1;
									cmd[k].alive_d    = 1'b1;
									cmd[k].asleep_we  = 1'b1;
									cmd[k].blocked_we = 1'b1;
									cmd[k].wake_we    = 1'b1;
									cmd[k].prio_we    = 1'b1;
									cmd[k].prio_d     = req_q.prio_in;
									cmd[k].idh_we     = 1'b1;
									cmd[k].idh_d      = addc_q;
									cmd[k].nxt_we     = 1'b1;
									cmd[k].nxt_d      = (total_q == '0) ? s : j;
									cmd[k].prv_we     = 1'b1;
									cmd[k].prv_d      = (total_q == '0) ? s : pj;
								end else if (total_q != '0) begin
									if (SLOT_W'(k) == pj) begin
										cmd[k].nxt_we = 1'b1;
										cmd[k].nxt_d  = s;
									end
									if (SLOT_W'(k) == j) begin
										cmd[k].prv_we = 1'b1;
										cmd[k].prv_d  = s;
									end
								end
							end
							nid_d   = {addc_q, ID_LOW_W'(s)};
							total_d = total_q + 1'b1;
							addc_d  = addc_q + 1'b1;
						end
					end
					REQ_ADD_PERIODIC: begin
						if (etot_q >= ECNT_W'(EVENT_SLOTS)) begin
							status_d = STS_LIMIT;
						end else begin
							for (int e = 0; e < EVENT_SLOTS; e++) begin
								if (ECNT_W'(e) == etot_q) begin
									ecmd[e].wr       = 1'b1;
									ecmd[e].period_d = req_q.period_in;
									ecmd[e].due_d    = TIME_W'(etot_q);
								end
							end
							etot_d = etot_q + 1'b1;
						end
					end
					REQ_LAUNCH: begin
						if (total_q == '0) begin
							status_d = STS_NO_THREADS;
						end else begin
							cur_d      = chain[THREAD_SLOTS].min_idx;
							launched_d = 1'b1;
						end
					end
					REQ_TICK: begin
						if (!launched_q) begin
							status_d = STS_NOT_RUNNING;
						end else begin
							for (int e = 0; e < EVENT_SLOTS; e++)
								ecmd[e].tick = (ECNT_W'(e) < etot_q);
							fired_d  = efire;
							time_d   = time_q + 1'b1;
							exec_tgt = ST_WAKE;
						end
					end
					REQ_SLEEP: begin
						if (!launched_q) begin
							status_d = STS_NOT_RUNNING;
						end else begin
							for (int k = 0; k < THREAD_SLOTS; k++) begin
								if (SLOT_W'(k) == cur_q) begin
									cmd[k].wake_we   = 1'b1;
									cmd[k].wake_d    = time_q + req_q.sleep_ticks;
									cmd[k].asleep_we = 1'b1;
									cmd[k].asleep_d  = 1'b1;
								end
							end
							exec_tgt = ST_RINIT;
						end
					end
					REQ_KILL_ID, REQ_KILL_SELF: begin
						if (req_t'(req_q.req_type) == REQ_KILL_SELF && !launched_q) begin
							status_d = STS_NOT_RUNNING;
						end else if (total_q == CNT_W'(1)) begin
							status_d = STS_KILL_LAST;
						end else if (req_t'(req_q.req_type) == REQ_KILL_ID &&
								!chain[THREAD_SLOTS].match_any) begin
							status_d = STS_NOT_FOUND;
						end else begin
							s = (req_t'(req_q.req_type) == REQ_KILL_SELF) ? cur_q :
								chain[THREAD_SLOTS].match_idx;
							p = stat[s].prv;
							n = stat[s].nxt;
							// unlink from the ring
							for (int k = 0; k < THREAD_SLOTS; k++) begin
								if (SLOT_W'(k) == p) begin
									cmd[k].nxt_we = 1'b1;
									cmd[k].nxt_d  = n;
								end
								if (SLOT_W'(k) == n) begin
									cmd[k].prv_we = 1'b1;
									cmd[k].prv_d  = p;
								end
								if (SLOT_W'(k) == s) begin
									cmd[k].alive_we   = 1'b1;
									cmd[k].asleep_we  = 1'b1;
									cmd[k].blocked_we = 1'b1;
								end
							end
							total_d = total_q - 1'b1;
							if (launched_q && s == cur_q) exec_tgt = ST_RINIT;
						end
					end
					REQ_SET_BLOCKED: begin
						if (!chain[THREAD_SLOTS].match_any) begin
							status_d = STS_NOT_FOUND;
						end else begin
							s = chain[THREAD_SLOTS].match_idx;
							for (int k = 0; k < THREAD_SLOTS; k++) begin
								if (SLOT_W'(k) == s) begin
									cmd[k].blocked_we = 1'b1;
									cmd[k].blocked_d  = req_q.block_flag;
								end
							end
							if (req_q.block_flag && launched_q && s == cur_q)
								exec_tgt = ST_RINIT;
						end
					end
					default: ;
				endcase
			end
			ST_WAKE: begin
				for (int k = 0; k < THREAD_SLOTS; k++) cmd[k].wake_chk = 1'b1;
			end
			ST_RINIT: begin
				t_d     = stat[cur_q].nxt;
				first_d = stat[cur_q].nxt;
				best_d  = BEST_W'(256);
				found_d = 1'b0;
				cnt_d   = '0;
			end
			ST_RSTEP: begin
				if (cnt_q == total_q) begin
					if (found_q) cur_d = cand_q;
					else if (!stat[cur_q].alive) cur_d = first_q;
				end else begin
					ready = !stat[t_q].asleep && !stat[t_q].blocked &&
						({1'b0, stat[t_q].prio} < best_q);
					if (ready) begin
						cand_d  = t_q;
						best_d  = {1'b0, stat[t_q].prio};
						found_d = 1'b1;
					end
					t_d   = stat[t_q].nxt;
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_EMIT: begin
				for (int e = EVENT_SLOTS - 1; e >= 0; e--)
					if (fired_q[e]) ev = EVT_W'(e);
				strobe_d           = 1'b1;
				res_d.running_id   = launched_q ? {stat[cur_q].id_high, ID_LOW_W'(cur_q)} : '0;
				res_d.running_slot = launched_q ? 3'(cur_q) : '0;
				res_d.live_threads = 4'(total_q);
				if (fired_q != '0) begin
					res_d.item_kind   = 1'b1;
					res_d.status      = STS_OK;
					res_d.fired_event = ev;
					res_d.new_id      = '0;
					res_d.last        = 1'b0;
					for (int e = 0; e < EVENT_SLOTS; e++)
						if (EVT_W'(e) == ev) fired_d[e] = 1'b0;
				end else begin
					res_d.item_kind   = 1'b0;
					res_d.status      = status_q;
					res_d.fired_event = '0;
					res_d.new_id      = nid_q;
					res_d.last        = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			total_q    <= '0;
			addc_q     <= '0;
			cur_q      <= '0;
			launched_q <= 1'b0;
			time_q     <= '0;
			etot_q     <= '0;
			fired_q    <= '0;
			strobe_q   <= 1'b0;
		end else begin
			state_q    <= state_d;
			total_q    <= total_d;
			addc_q     <= addc_d;
			cur_q      <= cur_d;
			launched_q <= launched_d;
			time_q     <= time_d;
			etot_q     <= etot_d;
			fired_q    <= fired_d;
			strobe_q   <= strobe_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		req_q    <= req_d;
		t_q      <= t_d;
		first_q  <= first_d;
		cand_q   <= cand_d;
		best_q   <= best_d;
		found_q  <= found_d;
		cnt_q    <= cnt_d;
		status_q <= status_d;
		nid_q    <= nid_d;
		res_q    <= res_d;
	end

endmodule
